FILE: design/wave_collapse_grid_solver_defines.svh
// Assertion macros for the checker file of the grid solver.
// Depends on nothing; every macro expects clk and rst in scope.
`ifndef WAVE_COLLAPSE_GRID_SOLVER_DEFINES_SVH
`define WAVE_COLLAPSE_GRID_SOLVER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define WCGS_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define WCGS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/wcgs_pkg.sv
// Package for the grid solver: opcodes, cell word layout, sequencer states
// and small tile helper functions. Depends on nothing.
`default_nettype none

package wcgs_pkg;

  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;
  localparam int DEF_FIFO_DEPTH = 8192;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_STEP  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Cell word: {tile[1:0], collapsed, mask[2:0]}.
  localparam logic [5:0] CELL_RESET = 6'b00_0_111;

  typedef enum logic [4:0] {
    ST_INIT, ST_IDLE, ST_CLR, ST_RD_ISSUE, ST_RD_EV,
    ST_S1_RD, ST_S1_EV, ST_KMUL, ST_S2_RD, ST_S2_EV,
    ST_TMUL, ST_TILE, ST_P_POP, ST_P_POPW, ST_P_CUR, ST_P_CRD, ST_P_CEV,
    ST_P_NB, ST_P_NBEV, ST_FIN
  } state_t;

  function automatic logic [1:0] popcnt3(input logic [2:0] m);
    popcnt3 = 2'(m[0]) + 2'(m[1]) + 2'(m[2]);
  endfunction

  // Tiles that a neighbor may hold next to any tile in m.
  function automatic logic [2:0] allowed_next_to(input logic [2:0] m);
    logic [2:0] a;
    a = 3'b000;
    if (m[0]) a = a | 3'b011;
    if (m[1]) a = a | 3'b111;
    if (m[2]) a = a | 3'b110;
    allowed_next_to = a;
  endfunction

  // The k-th set tile of m in ascending order.
  function automatic logic [1:0] pick_tile(input logic [2:0] m, input logic [1:0] k);
    logic [1:0] seen;
    logic [1:0] t;
    logic       found;
    seen = 2'd0;
    t = 2'd0;
    found = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (m[i] && !found) begin
        if (seen == k) begin
          t = 2'(i);
          found = 1'b1;
        end else begin
          seen = seen + 2'd1;
        end
      end
    end
    pick_tile = t;
  endfunction

endpackage

`default_nettype wire

FILE: design/wave_collapse_grid_solver.sv
// Top level of the grid solver: sequencer, cell memory and propagation queue.
// Depends on wcgs_pkg.
`default_nettype none

// Tile grid solver by constraint collapse. A clear transaction sweeps all
// MAX_WIDTH*MAX_HEIGHT cells of the cell memory, one cell a cycle. The same
// sweep runs after reset, and no transaction is accepted until it ends. A read
// addresses the cell memory, then takes the cell word into the result. A step
// scans every cell in use through the single read port of the cell memory to
// find the cells with fewest options, then scans again up to the chosen one if
// there is one. It then drains the propagation queue: each queued cell is popped
// and read, and each neighbor inside the grid is read and narrowed; the step
// ends when the queue is empty. The block takes one transaction at a time. A
// result waits in the output register while the next transaction may be accepted.
module wave_collapse_grid_solver #(
  parameter int MAX_WIDTH  = wcgs_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = wcgs_pkg::DEF_MAX_HEIGHT,
  parameter int FIFO_DEPTH = wcgs_pkg::DEF_FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [11:0] cell_index,
  input  logic [31:0] rand_cell,
  input  logic [31:0] rand_tile,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        done_res,
  output logic [11:0] cell_out,
  output logic [1:0]  tile_out,
  output logic        collapsed_out,
  output logic [2:0]  tile_mask_out
);
  import wcgs_pkg::*;

  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int CW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int NW    = $clog2(CELLS + 1);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int FW    = XW + YW;
  localparam int FAW   = $clog2(FIFO_DEPTH);
  localparam int FCW   = $clog2(FIFO_DEPTH + 1);
  localparam int PW    = 32 + NW;

  state_t state, state_next;

  // Configuration and effective dimensions.
  logic [6:0]   grid_width, grid_height;
  logic [WW-1:0] wd;
  logic [HW-1:0] hd;
  logic [NW-1:0] ncells;

  // Latched transaction.
  logic [11:0] idx;
  logic [31:0] rc, rt;

  // Scan state.
  logic [NW-1:0] scan_i;
  logic [XW-1:0] sx;
  logic [YW-1:0] sy;
  logic [1:0]    best;
  logic [NW-1:0] cnt, seen, kc;
  logic [1:0]    kt;
  logic [CW-1:0] target;
  logic [XW-1:0] tx, cx, nx;
  logic [YW-1:0] ty, cy, ny;
  logic [2:0]    tmask, allow;
  logic [CW-1:0] curr, naddr;
  logic [1:0]    dir;

  // Result being built.
  logic        r_done, r_coll;
  logic [11:0] r_cell;
  logic [1:0]  r_tile;
  logic [2:0]  r_mask;

  // Cell memory.
  logic [5:0]    cell_mem [CELLS];
  logic [5:0]    cell_rdata;
  logic [CW-1:0] cell_ra, cell_wa;
  logic [5:0]    cell_wd;
  logic          cell_we;

  // Propagation queue.
  logic [FW-1:0]  fifo_mem [FIFO_DEPTH];
  logic [FW-1:0]  fifo_rdata;
  logic [FAW-1:0] head, tail;
  logic [FCW-1:0] fcount;
  logic [FW-1:0]  fifo_wd;
  logic           fifo_we;

  logic [PW-1:0] prod_c;
  logic [33:0]   prod_t;
  logic [1:0]    tile_sel;
  logic          nb_ok;
  logic [CW-1:0] nb_addr;
  logic [XW-1:0] nb_x;
  logic [YW-1:0] nb_y;
  logic          last_x;
  logic          nb_change;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);

  assign wd = (grid_width == 7'd0) ? WW'(1) :
              (9'(grid_width) > 9'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(grid_width);
  assign hd = (grid_height == 7'd0) ? HW'(1) :
              (9'(grid_height) > 9'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(grid_height);
  assign ncells = NW'(NW'(wd) * NW'(hd));

  assign prod_c   = PW'(rc) * PW'(cnt);
  assign prod_t   = 34'(rt) * 34'(best);
  assign tile_sel = pick_tile(tmask, kt);
  assign last_x   = (WW'(sx) + WW'(1)) == wd;

  // Neighbor selection for the current direction.
  always_comb begin
    nb_ok   = 1'b0;
    nb_addr = curr;
    nb_x    = cx;
    nb_y    = cy;
    case (dir)
      2'd0: begin
        nb_ok   = (cy != '0);
        nb_addr = curr - CW'(wd);
        nb_y    = cy - YW'(1);
      end
      2'd1: begin
        nb_ok   = (HW'(cy) + HW'(1)) < hd;
        nb_addr = curr + CW'(wd);
        nb_y    = cy + YW'(1);
      end
      2'd2: begin
        nb_ok   = (cx != '0);
        nb_addr = curr - CW'(1);
        nb_x    = cx - XW'(1);
      end
      default: begin
        nb_ok   = (WW'(cx) + WW'(1)) < wd;
        nb_addr = curr + CW'(1);
        nb_x    = cx + XW'(1);
      end
    endcase
  end

  assign nb_change = !cell_rdata[3] && ((cell_rdata[2:0] & allow) != cell_rdata[2:0]);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: if (scan_i == NW'(CELLS - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) begin
          case (opcode)
            OP_CLEAR: state_next = ST_CLR;
            OP_STEP:  state_next = ST_S1_RD;
            OP_READ:  state_next = ST_RD_ISSUE;
            default:  state_next = ST_FIN;
          endcase
        end
      end
      ST_CLR:      if (scan_i == NW'(CELLS - 1)) state_next = ST_FIN;
      ST_RD_ISSUE: state_next = ST_RD_EV;
      ST_RD_EV:    state_next = ST_FIN;
      ST_S1_RD:    state_next = (scan_i == ncells) ? ST_KMUL : ST_S1_EV;
      ST_S1_EV:    state_next = ST_S1_RD;
      ST_KMUL:     state_next = (cnt == '0) ? ST_FIN : ST_S2_RD;
      ST_S2_RD:    state_next = ST_S2_EV;
      ST_S2_EV: begin
        if (!cell_rdata[3] && popcnt3(cell_rdata[2:0]) == best && seen == kc)
          state_next = ST_TMUL;
        else
          state_next = ST_S2_RD;
      end
      ST_TMUL:   state_next = ST_TILE;
      ST_TILE:   state_next = ST_P_POP;
      ST_P_POP:  state_next = (fcount == '0) ? ST_FIN : ST_P_POPW;
      ST_P_POPW: state_next = ST_P_CUR;
      ST_P_CUR:  state_next = ST_P_CRD;
      ST_P_CRD:  state_next = ST_P_CEV;
      ST_P_CEV:  state_next = ST_P_NB;
      ST_P_NB: begin
        if (nb_ok) state_next = ST_P_NBEV;
        else if (dir == 2'd3) state_next = ST_P_POP;
      end
      ST_P_NBEV: state_next = (dir == 2'd3) ? ST_P_POP : ST_P_NB;
      ST_FIN:    if (!out_valid || out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Memory controls.
  always_comb begin
    cell_ra = scan_i[CW-1:0];
    cell_we = 1'b0;
    cell_wa = scan_i[CW-1:0];
    cell_wd = CELL_RESET;
    fifo_we = 1'b0;
    fifo_wd = {nb_y, nb_x};
    case (state)
      ST_INIT, ST_CLR: cell_we = 1'b1;
      ST_RD_ISSUE: cell_ra = CW'(idx);
      ST_TILE: begin
        cell_we = 1'b1;
        cell_wa = target;
        cell_wd = {tile_sel, 1'b1, 3'(3'b001 << tile_sel)};
        fifo_we = 1'b1;
        fifo_wd = {ty, tx};
      end
      ST_P_CRD: cell_ra = curr;
      ST_P_NB:  cell_ra = nb_addr;
      ST_P_NBEV: begin
        cell_wa = naddr;
        cell_wd = {cell_rdata[5:3], cell_rdata[2:0] & allow};
        cell_we = nb_change;
        fifo_wd = {ny, nx};
        fifo_we = nb_change && (fcount < FCW'(FIFO_DEPTH));
      end
      default: ;
    endcase
  end

  // Cell memory and queue memory.
  always_ff @(posedge clk) begin
    if (cell_we) cell_mem[cell_wa] <= cell_wd;
    cell_rdata <= cell_mem[cell_ra];
    if (fifo_we) fifo_mem[(state == ST_TILE) ? FAW'(0) : tail] <= fifo_wd;
    fifo_rdata <= fifo_mem[head];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_INIT;
      grid_width  <= 7'd16;
      grid_height <= 7'd16;
      out_valid   <= 1'b0;
      scan_i      <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        if (cfg_index == REG_WIDTH) grid_width <= cfg_data;
        else grid_height <= cfg_data;
      end
      if (state == ST_FIN && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE:  scan_i <= '0;
        ST_INIT, ST_CLR, ST_S1_EV, ST_S2_EV: scan_i <= scan_i + NW'(1);
        ST_KMUL:  scan_i <= '0;
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        idx    <= cell_index;
        rc     <= rand_cell;
        rt     <= rand_tile;
        sx     <= '0;
        sy     <= '0;
        best   <= 2'd0;
        cnt    <= '0;
        r_done <= 1'b0;
        r_cell <= 12'd0;
        r_tile <= 2'd0;
        r_coll <= 1'b0;
        r_mask <= 3'd0;
        if (opcode == OP_READ) r_cell <= cell_index;
      end
      ST_RD_EV: begin
        if (32'(idx) < 32'(ncells)) begin
          r_tile <= cell_rdata[5:4];
          r_coll <= cell_rdata[3];
          r_mask <= cell_rdata[2:0];
        end
      end
      ST_S1_EV: begin
        if (!cell_rdata[3] && cell_rdata[2:0] != 3'd0) begin
          if (best == 2'd0 || popcnt3(cell_rdata[2:0]) < best) begin
            best <= popcnt3(cell_rdata[2:0]);
            cnt  <= NW'(1);
          end else if (popcnt3(cell_rdata[2:0]) == best) begin
            cnt <= cnt + NW'(1);
          end
        end
      end
      ST_KMUL: begin
        kc     <= prod_c[PW-1:32];
        seen   <= '0;
        sx     <= '0;
        sy     <= '0;
        r_done <= (cnt == '0);
      end
      ST_S2_EV: begin
        if (!cell_rdata[3] && popcnt3(cell_rdata[2:0]) == best) begin
          seen <= seen + NW'(1);
          if (seen == kc) begin
            target <= scan_i[CW-1:0];
            tx     <= sx;
            ty     <= sy;
            tmask  <= cell_rdata[2:0];
          end
        end
        if (last_x) begin
          sx <= '0;
          sy <= sy + YW'(1);
        end else begin
          sx <= sx + XW'(1);
        end
      end
      ST_TMUL: kt <= prod_t[33:32];
      ST_TILE: begin
        r_cell <= 12'(target);
        r_tile <= tile_sel;
        r_coll <= 1'b1;
        r_mask <= 3'(3'b001 << tile_sel);
        head   <= '0;
        tail   <= FAW'(1);
        fcount <= FCW'(1);
      end
      ST_P_POP: begin
        if (fcount != '0) begin
          head   <= (head == FAW'(FIFO_DEPTH - 1)) ? '0 : head + FAW'(1);
          fcount <= fcount - FCW'(1);
        end
      end
      ST_P_POPW: begin
        cy <= fifo_rdata[FW-1:XW];
        cx <= fifo_rdata[XW-1:0];
      end
      ST_P_CUR: curr <= CW'(NW'(NW'(cy) * NW'(wd)) + NW'(cx));
      ST_P_CEV: begin
        allow <= allowed_next_to(cell_rdata[2:0]);
        dir   <= 2'd0;
      end
      ST_P_NB: begin
        naddr <= nb_addr;
        nx    <= nb_x;
        ny    <= nb_y;
        if (!nb_ok) dir <= dir + 2'd1;
      end
      ST_P_NBEV: begin
        dir <= dir + 2'd1;
        if (fifo_we) begin
          tail   <= (tail == FAW'(FIFO_DEPTH - 1)) ? '0 : tail + FAW'(1);
          fcount <= fcount + FCW'(1);
        end
      end
      ST_FIN: begin
        if (!out_valid || out_ready) begin
          done_res      <= r_done;
          cell_out      <= r_cell;
          tile_out      <= r_tile;
          collapsed_out <= r_coll;
          tile_mask_out <= r_mask;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: design/wcgs_checker.sv
// Port-level checker for the grid solver, bound to the top level.
// Depends on wave_collapse_grid_solver_defines.svh.
`default_nettype none
`include "wave_collapse_grid_solver_defines.svh"

module wcgs_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        done_res,
  input wire logic [11:0] cell_out,
  input wire logic [1:0]  tile_out,
  input wire logic        collapsed_out,
  input wire logic [2:0]  tile_mask_out
);

  // A held result keeps its cell and mask until the transaction completes.
  `WCGS_ASSERT_NEXT(a_hold, out_valid && !out_ready,
                    out_valid && $stable(cell_out) && $stable(tile_mask_out),
                    "result changed while stalled")

  // The block is busy right after it takes a transaction.
  `WCGS_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "ready right after accept")

  // A step with no candidate reports nothing else.
  `WCGS_ASSERT(a_done, out_valid && done_res,
               cell_out == 12'd0 && tile_mask_out == 3'd0 && !collapsed_out,
               "done result not clean")

  // A collapsed cell holds exactly its final tile.
  `WCGS_ASSERT(a_coll, out_valid && collapsed_out,
               tile_mask_out == 3'(3'b001 << tile_out), "collapsed mask mismatch")

endmodule

bind wave_collapse_grid_solver wcgs_checker u_wcgs_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .done_res(done_res),
  .cell_out(cell_out), .tile_out(tile_out), .collapsed_out(collapsed_out),
  .tile_mask_out(tile_mask_out)
);

`default_nettype wire

FILE: tb/wave_collapse_grid_solver_checker.sv
// Checker for the grid solver: watches the register, input and result channels,
// keeps its own copy of the cell grid and compares each result with a prediction.
// Depends on wcgs_pkg.
module wave_collapse_grid_solver_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [11:0] cell_index,
  input  logic [31:0] rand_cell,
  input  logic [31:0] rand_tile,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        done_res,
  input  logic [11:0] cell_out,
  input  logic [1:0]  tile_out,
  input  logic        collapsed_out,
  input  logic [2:0]  tile_mask_out,
  output int          errors,
  output int          outstanding,
  output int          checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import wcgs_pkg::*;

  localparam int NUM_CELLS = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
  localparam int EXP_DEPTH = 16;

  typedef struct packed {
    logic        done;
    logic [11:0] cell_idx;
    logic [1:0]  tile;
    logic        coll;
    logic [2:0]  mask;
  } cell_result_t;

  // Shadow grid and register copies.
  logic [2:0]   shadow_mask [NUM_CELLS];
  logic         shadow_coll [NUM_CELLS];
  logic [1:0]   shadow_tile [NUM_CELLS];
  logic [6:0]   width_reg;
  logic [6:0]   height_reg;

  // Predictions waiting for their result transaction, kept as a ring.
  cell_result_t expected_q [EXP_DEPTH];
  int           exp_rd;
  int           exp_wr;
  int           exp_count;

  function automatic int clamp_dim(logic [6:0] v, int max_dim);
    if (v == 0) return 1;
    if (v > max_dim) return max_dim;
    return v;
  endfunction

  function automatic int tile_count(logic [2:0] m);
    return m[0] + m[1] + m[2];
  endfunction

  // Tiles permitted beside a cell whose options are m: tiles 0 and 2 never touch.
  function automatic logic [2:0] neighbor_allow(logic [2:0] m);
    logic [2:0] a;
    a = 3'b000;
    if (m[0]) a |= 3'b011;
    if (m[1]) a |= 3'b111;
    if (m[2]) a |= 3'b110;
    return a;
  endfunction

  function automatic void wipe_grid();
    for (int i = 0; i < NUM_CELLS; i++) begin
      shadow_mask[i] = 3'b111;
      shadow_coll[i] = 1'b0;
      shadow_tile[i] = 2'd0;
    end
  endfunction

  // Breadth-first narrowing of the neighbors of a freshly collapsed cell.
  function automatic void spread_constraints(int start, int w, int h);
    int worklist [DEF_FIFO_DEPTH];
    int wl_head, wl_count;
    int curr, x, y, nb;
    logic [2:0] allow, nm;
    wl_head = 0;
    worklist[0] = start;
    wl_count = 1;
    while (wl_count > 0) begin
      curr = worklist[wl_head];
      wl_head = (wl_head + 1) % DEF_FIFO_DEPTH;
      wl_count--;
      x = curr % w;
      y = curr / w;
      allow = neighbor_allow(shadow_mask[curr]);
      for (int d = 0; d < 4; d++) begin
        case (d)
          0: nb = (y > 0) ? curr - w : -1;
          1: nb = (y + 1 < h) ? curr + w : -1;
          2: nb = (x > 0) ? curr - 1 : -1;
          default: nb = (x + 1 < w) ? curr + 1 : -1;
        endcase
        if (nb >= 0 && !shadow_coll[nb]) begin
          nm = shadow_mask[nb] & allow;
          if (nm != shadow_mask[nb]) begin
            shadow_mask[nb] = nm;
            if (wl_count < DEF_FIFO_DEPTH) begin
              worklist[(wl_head + wl_count) % DEF_FIFO_DEPTH] = nb;
              wl_count++;
            end
          end
        end
      end
    end
  endfunction

  // Works out the result of one accepted transaction and updates the grid.
  function automatic cell_result_t solve_transaction(logic [1:0] op, logic [11:0] idx,
                                                     logic [31:0] rc, logic [31:0] rt);
    cell_result_t r;
    int w, h, n, best, cnt, k, seen, target, e;
    logic [63:0] prod;
    logic [2:0] m;
    logic [1:0] t;
    r = '0;
    w = clamp_dim(width_reg, DEF_MAX_WIDTH);
    h = clamp_dim(height_reg, DEF_MAX_HEIGHT);
    n = w * h;
    if (op == OP_CLEAR) begin
      wipe_grid();
    end else if (op == OP_READ) begin
      r.cell_idx = idx;
      if (idx < n) begin
        r.tile = shadow_tile[idx];
        r.coll = shadow_coll[idx];
        r.mask = shadow_mask[idx];
      end
    end else if (op == OP_STEP) begin
      best = 4;
      cnt = 0;
      for (int i = 0; i < n; i++) begin
        e = tile_count(shadow_mask[i]);
        if (!shadow_coll[i] && e != 0) begin
          if (e < best) begin
            best = e;
            cnt = 1;
          end else if (e == best) begin
            cnt++;
          end
        end
      end
      if (cnt == 0) begin
        r.done = 1'b1;
        return r;
      end
      prod = {32'd0, rc} * 64'(cnt);
      k = prod[63:32];
      seen = 0;
      target = 0;
      for (int i = 0; i < n; i++) begin
        if (!shadow_coll[i] && tile_count(shadow_mask[i]) == best) begin
          if (seen == k) begin
            target = i;
            break;
          end
          seen++;
        end
      end
      m = shadow_mask[target];
      prod = {32'd0, rt} * 64'(best);
      k = prod[63:32];
      seen = 0;
      t = 2'd0;
      for (int i = 0; i < 3; i++) begin
        if (m[i]) begin
          if (seen == k) begin
            t = 2'(i);
            break;
          end
          seen++;
        end
      end
      shadow_tile[target] = t;
      shadow_coll[target] = 1'b1;
      shadow_mask[target] = 3'b001 << t;
      spread_constraints(target, w, h);
      r.cell_idx = 12'(target);
      r.tile = t;
      r.coll = 1'b1;
      r.mask = 3'b001 << t;
    end
    return r;
  endfunction

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  initial begin
    errors = 0;
    outstanding = 0;
    checked = 0;
    exp_rd = 0;
    exp_wr = 0;
    exp_count = 0;
    width_reg = 7'd16;
    height_reg = 7'd16;
    wipe_grid();
  end

  // Per edge: compare a delivered result first, then register and input transactions.
  always @(posedge clk) begin
    cell_result_t exp_r;
    if (rst) begin
      wipe_grid();
      width_reg <= 7'd16;
      height_reg <= 7'd16;
      exp_rd = 0;
      exp_wr = 0;
      exp_count = 0;
      outstanding <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (exp_count == 0) begin
          $error("result transaction with no prediction pending (cell_out %0d)", cell_out);
          errors++;
        end else begin
          exp_r = expected_q[exp_rd];
          exp_rd = (exp_rd + 1) % EXP_DEPTH;
          exp_count--;
          check_field("done_res", exp_r.done, done_res);
          check_field("cell_out", exp_r.cell_idx, cell_out);
          check_field("tile_out", exp_r.tile, tile_out);
          check_field("collapsed_out", exp_r.coll, collapsed_out);
          check_field("tile_mask_out", exp_r.mask, tile_mask_out);
          checked++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_WIDTH) width_reg = cfg_data;
        else height_reg = cfg_data;
      end
      if (in_valid && in_ready) begin
        if (exp_count == EXP_DEPTH) begin
          $error("too many input transactions without a result");
          errors++;
        end else begin
          expected_q[exp_wr] = solve_transaction(opcode, cell_index, rand_cell, rand_tile);
          exp_wr = (exp_wr + 1) % EXP_DEPTH;
          exp_count++;
        end
      end
      outstanding <= exp_count;
    end
  end

endmodule

FILE: tb/tb_wave_collapse_grid_solver.sv
// Top of the grid solver testbench: clock, reset, stimulus and verdict.
// Depends on wcgs_pkg, wave_collapse_grid_solver and its checker module.
module tb_wave_collapse_grid_solver;
  timeunit 1ns;
  timeprecision 1ps;
  import wcgs_pkg::*;

  localparam logic [1:0] OP_NOP = 2'd3;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [6:0]  cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  opcode;
  logic [11:0] cell_index;
  logic [31:0] rand_cell;
  logic [31:0] rand_tile;
  logic        out_valid;
  logic        out_ready;
  logic        done_res;
  logic [11:0] cell_out;
  logic [1:0]  tile_out;
  logic        collapsed_out;
  logic [2:0]  tile_mask_out;
  int          errors;
  int          outstanding;
  int          checked;
  int          sent;
  int          shapes;
  bit          steady;

  wave_collapse_grid_solver i_dut (.*);

  wave_collapse_grid_solver_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side: random stall before each transaction, none in steady phases.
  initial begin
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_item(logic [1:0] op, logic [11:0] idx, logic [31:0] rc,
                           logic [31:0] rt);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    cell_index <= idx;
    rand_cell <= rc;
    rand_tile <= rt;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // Register writes happen only once every pending result has come back.
  task automatic write_reg(logic idx, logic [6:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // One grid shape: set the size, optionally clear, then a random mix that is
  // mostly collapse steps with reads, clears and no-op opcodes in between.
  task automatic run_shape(logic [6:0] w, logic [6:0] h, bit with_clear, int count);
    int n, r;
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    shapes++;
    steady = ($urandom_range(0, 3) == 0);
    n = (w == 0 ? 1 : (w > 64 ? 64 : w)) * (h == 0 ? 1 : (h > 64 ? 64 : h));
    if (with_clear) send_item(OP_CLEAR, 12'($urandom), $urandom, $urandom);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 60)
        send_item(OP_STEP, 12'($urandom), $urandom, $urandom);
      else if (r < 80)
        send_item(OP_READ, 12'($urandom_range(0, n - 1)), $urandom, $urandom);
      else if (r < 88)
        send_item(OP_READ, 12'($urandom), $urandom, $urandom);
      else if (r < 94)
        send_item(OP_CLEAR, 12'($urandom), $urandom, $urandom);
      else
        send_item(OP_NOP, 12'($urandom), $urandom, $urandom);
    end
  endtask

  initial begin
    sent = 0;
    shapes = 1;
    steady = 1'b0;
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= REG_WIDTH;
    cfg_data <= 7'd0;
    in_valid <= 1'b0;
    opcode <= OP_CLEAR;
    cell_index <= 12'd0;
    rand_cell <= 32'd0;
    rand_tile <= 32'd0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part on the reset grid: field extremes, every opcode, no-op
    // opcode, reads outside the grid, and a clear in the middle.
    send_item(OP_READ, 12'd0, 32'd0, 32'd0);
    send_item(OP_READ, 12'd4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_STEP, 12'd0, 32'd0, 32'd0);
    send_item(OP_STEP, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_STEP, 12'd0, 32'h8000_0000, 32'h5555_5555);
    send_item(OP_READ, 12'd255, 32'd0, 32'd0);
    send_item(OP_READ, 12'd256, 32'd0, 32'd0);
    send_item(OP_NOP, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_STEP, 12'd0, 32'hAAAA_AAAA, 32'hAAAA_AAAA);
    send_item(OP_CLEAR, 12'd0, 32'd0, 32'd0);
    send_item(OP_READ, 12'd17, 32'd0, 32'd0);
    send_item(OP_STEP, 12'd0, 32'h0000_0001, 32'hFFFF_FFFE);

    // A single cell: the second step must report done.
    run_shape(7'd1, 7'd1, 1'b1, 0);
    send_item(OP_STEP, 12'd0, $urandom, $urandom);
    send_item(OP_STEP, 12'd0, $urandom, $urandom);
    send_item(OP_READ, 12'd0, 32'd0, 32'd0);
    send_item(OP_READ, 12'd1, 32'd0, 32'd0);

    // Largest grid, kept short since each step scans all of it.
    run_shape(7'd64, 7'd64, 1'b1, 0);
    send_item(OP_STEP, 12'd0, $urandom, $urandom);
    send_item(OP_STEP, 12'd0, $urandom, $urandom);
    send_item(OP_READ, 12'd4095, 32'd0, 32'd0);

    // Out-of-range sizes are clamped.
    run_shape(7'd0, 7'd127, 1'b1, 14);
    run_shape(7'd127, 7'd0, 1'b1, 10);
    run_shape(7'd5, 7'd7, 1'b1, 22);
    run_shape(7'd3, 7'd4, 1'b1, 18);
    // Size changed without a clear: the stored cells are used as they stand.
    run_shape(7'd2, 7'd2, 1'b0, 8);
    run_shape(7'd16, 7'd16, 1'b1, 8);

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Ran %0d input transactions over %0d grid shapes; %0d results compared.",
             sent, shapes, checked);
    if (errors == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #10_000_000;
    $display("Timeout: run did not finish.");
    $display("Simulation FAILED");
    $finish;
  end

endmodule
